FILE: hdl/vegu_pkg.sv
// ----------------------------------------------------------------------------
// vegu_pkg
// shared types, constants and helper functions of the voxel grid update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vegu_pkg;

	// grid geometry and occupancy format
	localparam int DIM_X    = 64;
	localparam int DIM_Y    = 64;
	localparam int DIM_Z    = 64;
	localparam int OCC_BITS = 8;
	localparam int CELLS    = DIM_X * DIM_Y * DIM_Z;
	localparam int CELL_AW  = $clog2(CELLS);
	localparam int SUM_W    = 17;

	localparam logic [OCC_BITS-1:0] OCC_FULL = '1;
	localparam logic [OCC_BITS-1:0] OCC_HALF = OCC_BITS'(1) << (OCC_BITS - 1);

	// register port
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_LIDAR_INC = 3'd0;
	localparam logic [2:0] REG_LIDAR_DEC = 3'd1;
	localparam logic [2:0] REG_OCC_THR   = 3'd2;
	localparam logic [2:0] REG_FREE_THR  = 3'd3;
	localparam logic [2:0] REG_SIZE_X    = 3'd4;
	localparam logic [2:0] REG_SIZE_Y    = 3'd5;
	localparam logic [2:0] REG_SIZE_Z    = 3'd6;

	// sensor kinds
	localparam logic [1:0] ACT_LIDAR  = 2'd0;
	localparam logic [1:0] ACT_CAMERA = 2'd1;
	localparam logic [1:0] ACT_ROBOT  = 2'd2;

	typedef enum logic [1:0] {
		CLS_UNKNOWN    = 2'd0,
		CLS_UNOCCUPIED = 2'd1,
		CLS_EXPLORED   = 2'd2,
		CLS_OCCUPIED   = 2'd3
	} class_t;

	typedef struct packed {
		logic [7:0] lidar_inc;
		logic [7:0] lidar_dec;
		logic [7:0] occ_thr;
		logic [7:0] free_thr;
		logic [6:0] size_x;
		logic [6:0] size_y;
		logic [6:0] size_z;
	} cfg_t;

	typedef struct packed {
		logic [OCC_BITS-1:0] occ;
		logic                observed;
		class_t              cls;
	} cell_t;

	typedef struct packed {
		logic [1:0]          action;
		logic signed [15:0]  cell_x;
		logic signed [15:0]  cell_y;
		logic signed [15:0]  cell_z;
		logic                hit;
		logic                ray_start;
		logic signed [15:0]  root_x;
		logic signed [15:0]  root_y;
		logic signed [15:0]  root_z;
	} in_item_t;

	typedef struct packed {
		logic [5:0] out_x;
		logic [5:0] out_y;
		logic [5:0] out_z;
		logic [1:0] new_class;
	} out_item_t;

	// control handed to the cell update logic
	typedef struct packed {
		logic [1:0] action;
		logic       hit;
		logic       near_root;
		logic       skip;
		logic       act_ok;
	} upd_ctl_t;

	typedef struct packed {
		cell_t wcell;
		logic  skip;
		logic  emit;
	} upd_res_t;

	function automatic class_t classify(input logic [OCC_BITS-1:0] occ,
			input logic obs, input logic [7:0] othr, input logic [7:0] fthr);
		class_t c;
		if (16'(occ) > 16'(othr)) begin
			c = CLS_OCCUPIED;
		end else if (obs) begin
			c = CLS_EXPLORED;
		end else if (16'(occ) < 16'(fthr)) begin
			c = CLS_UNOCCUPIED;
		end else begin
			c = CLS_UNKNOWN;
		end
		return c;
	endfunction

	function automatic logic axis_in(input logic signed [15:0] c, input logic [6:0] size,
			input int dim);
		logic [31:0] lim;
		lim = (32'(size) < 32'(dim)) ? 32'(size) : 32'(dim);
		return !c[15] && (32'(c[14:0]) < lim);
	endfunction

	function automatic logic near(input logic signed [15:0] a, input logic signed [15:0] b);
		logic signed [16:0] d;
		d = $signed({a[15], a}) - $signed({b[15], b});
		return (d >= -17'sd1) && (d <= 17'sd1);
	endfunction

	function automatic logic [CELL_AW-1:0] cell_index(input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		logic [31:0] i;
		i = (32'(x[14:0]) * 32'(DIM_Y) + 32'(y[14:0])) * 32'(DIM_Z) + 32'(z[14:0]);
		return i[CELL_AW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/vegu_ram.sv
// ----------------------------------------------------------------------------
// vegu_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vegu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/vegu_cfg_regs.sv
// ----------------------------------------------------------------------------
// vegu_cfg_regs
// register bank behind the apb port: lidar steps, thresholds, grid size
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vegu_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vegu_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output vegu_pkg::cfg_t                     cfg
);
	import vegu_pkg::*;

	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.lidar_inc <= 8'd64;
			cfg.lidar_dec <= 8'd32;
			cfg.occ_thr   <= 8'd178;
			cfg.free_thr  <= 8'd76;
			cfg.size_x    <= 7'd64;
			cfg.size_y    <= 7'd64;
			cfg.size_z    <= 7'd64;
		end else if (wr) begin
			case (idx)
				REG_LIDAR_INC: cfg.lidar_inc <= pwdata[7:0];
				REG_LIDAR_DEC: cfg.lidar_dec <= pwdata[7:0];
				REG_OCC_THR:   cfg.occ_thr   <= pwdata[7:0];
				REG_FREE_THR:  cfg.free_thr  <= pwdata[7:0];
				REG_SIZE_X:    cfg.size_x    <= pwdata[6:0];
				REG_SIZE_Y:    cfg.size_y    <= pwdata[6:0];
				REG_SIZE_Z:    cfg.size_z    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LIDAR_INC: prdata = 32'(cfg.lidar_inc);
			REG_LIDAR_DEC: prdata = 32'(cfg.lidar_dec);
			REG_OCC_THR:   prdata = 32'(cfg.occ_thr);
			REG_FREE_THR:  prdata = 32'(cfg.free_thr);
			REG_SIZE_X:    prdata = 32'(cfg.size_x);
			REG_SIZE_Y:    prdata = 32'(cfg.size_y);
			REG_SIZE_Z:    prdata = 32'(cfg.size_z);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/vegu_cell_update.sv
// ----------------------------------------------------------------------------
// vegu_cell_update
// modify step of the cell read-modify-write: occupancy, observe, reclassify
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vegu_cell_update (
	input  vegu_pkg::cfg_t     cfg,
	input  vegu_pkg::upd_ctl_t ctl,
	input  vegu_pkg::cell_t    cur,
	output vegu_pkg::upd_res_t res
);
	import vegu_pkg::*;

	logic [SUM_W-1:0]    occ_ext;
	logic [SUM_W-1:0]    inc;
	logic [SUM_W-1:0]    dec;
	logic [SUM_W-1:0]    sum;
	logic [OCC_BITS-1:0] nocc;
	logic                do_occ;
	logic                do_obs;
	cell_t               c;
	logic                skip;

	assign occ_ext = SUM_W'(cur.occ);
	assign inc     = (ctl.action == ACT_LIDAR) ? SUM_W'(cfg.lidar_inc) : SUM_W'(OCC_FULL);
	assign dec     = (ctl.action == ACT_LIDAR) ? SUM_W'(cfg.lidar_dec) : SUM_W'(OCC_FULL);
	assign sum     = occ_ext + inc;
	assign do_occ  = ctl.act_ok && (ctl.action == ACT_LIDAR || ctl.action == ACT_ROBOT);
	assign do_obs  = ctl.act_ok && (ctl.action == ACT_CAMERA || ctl.action == ACT_ROBOT);

	always_comb begin
		if (ctl.hit) begin
			nocc = (sum > SUM_W'(OCC_FULL)) ? OCC_FULL : sum[OCC_BITS-1:0];
		end else begin
			nocc = (occ_ext < dec) ? '0 : cur.occ - dec[OCC_BITS-1:0];
		end
	end

	always_comb begin
		c    = cur;
		skip = ctl.skip;
		if (do_occ && nocc != cur.occ) begin
			c.occ = nocc;
			c.cls = classify(nocc, cur.observed, cfg.occ_thr, cfg.free_thr);
		end
		if (do_obs) begin
			// back near the root ends a skipped stretch
			if (skip && ctl.near_root) begin
				skip = 1'b0;
			end
			if (!skip) begin
				if (c.cls == CLS_OCCUPIED || c.cls == CLS_UNKNOWN) begin
					skip = 1'b1;
				end else if (!c.observed) begin
					c.observed = 1'b1;
					c.cls      = classify(c.occ, 1'b1, cfg.occ_thr, cfg.free_thr);
				end
			end
		end
		res.wcell = c;
		res.skip  = skip;
		res.emit  = ctl.act_ok && (c.cls != cur.cls);
	end

endmodule

`default_nettype wire

FILE: hdl/voxel_exploration_grid_update.sv
// ----------------------------------------------------------------------------
// voxel_exploration_grid_update
// occupancy grid update for ray-traced cells: lidar occupancy steps, camera
// observation with skipping behind blocked cells, robot-volume forcing; a
// cell whose class changes is sent out
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  cell     in         cell_valid / cell_stall   cell_item (vegu_pkg::in_item_t)
//  upd      out        upd_valid / upd_stall     upd_item  (vegu_pkg::out_item_t)
//  apb      in         psel/penable/pready       paddr, pwdata, prdata
//
//  an item passes the cell memory read, then the modify and write back; a
//  new item is taken only once the one in flight has finished
//  after reset a clearing pass writes every cell, with cell_stall high
//  throughout; register writes are taken meanwhile
//  a stalled result holds in the output register; a new item is still taken
//  while it waits, and only an item that changes a class waits behind it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_exploration_grid_update (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// traced cells
	input  wire logic                          cell_valid,
	output logic                               cell_stall,
	input  vegu_pkg::in_item_t                 cell_item,
	// class changes
	output logic                               upd_valid,
	input  wire logic                          upd_stall,
	output vegu_pkg::out_item_t                upd_item,
	// register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vegu_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import vegu_pkg::*;

	cfg_t cfg;

	// clearing pass
	logic               clearing_q;
	logic [CELL_AW-1:0] clr_cnt_q;

	// item in the modify stage
	logic               v_s1;
	logic [1:0]         action_s1;
	logic               hit_s1;
	logic               start_s1;
	logic               near_s1;
	logic               ok_s1;
	logic [CELL_AW-1:0] addr_s1;
	logic [5:0]         ox_s1;
	logic [5:0]         oy_s1;
	logic [5:0]         oz_s1;

	logic               skipping_q;
	logic               upd_valid_q;
	out_item_t          upd_item_q;

	logic               accept;
	logic               in_grid;
	logic               out_free;
	logic               done;
	logic [CELL_AW-1:0] raddr;
	logic [CELL_AW-1:0] waddr;
	logic               we;
	cell_t              wdata;
	logic [$bits(cell_t)-1:0] rdata;
	cell_t              cur;
	upd_ctl_t           ctl;
	upd_res_t           res;

	vegu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one item at a time; nothing taken while the memory is being cleared
	assign cell_stall = clearing_q || v_s1;
	assign accept     = cell_valid && !cell_stall;

	assign in_grid = axis_in(cell_item.cell_x, cfg.size_x, DIM_X) &&
			axis_in(cell_item.cell_y, cfg.size_y, DIM_Y) &&
			axis_in(cell_item.cell_z, cfg.size_z, DIM_Z);

	// read the new cell on accept, keep reading the held cell while it waits
	assign raddr = v_s1 ? addr_s1 :
			cell_index(cell_item.cell_x, cell_item.cell_y, cell_item.cell_z);

	vegu_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cur = cell_t'(rdata);

	// ray start drops skipping before anything else
	assign ctl.action    = action_s1;
	assign ctl.hit       = hit_s1;
	assign ctl.near_root = near_s1;
	assign ctl.skip      = start_s1 ? 1'b0 : skipping_q;
	assign ctl.act_ok    = ok_s1;

	vegu_cell_update u_upd (
		.cfg (cfg),
		.ctl (ctl),
		.cur (cur),
		.res (res)
	);

	// the item finishes unless its result finds the output register occupied and stalled
	assign out_free = !upd_valid_q || !upd_stall;
	assign done     = v_s1 && (!res.emit || out_free);

	// write port: reset pattern during the clearing pass, updated cell otherwise
	assign we    = clearing_q || (done && ok_s1);
	assign waddr = clearing_q ? clr_cnt_q : addr_s1;
	always_comb begin
		if (clearing_q) begin
			wdata.occ      = OCC_HALF;
			wdata.observed = 1'b0;
			wdata.cls      = CLS_UNKNOWN;
		end else begin
			wdata = res.wcell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == CELL_AW'(CELLS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + CELL_AW'(1);
			end
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			skipping_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (done) begin
				v_s1 <= 1'b0;
			end
			if (done) begin
				skipping_q <= res.skip;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= cell_item.action;
			hit_s1    <= cell_item.hit;
			start_s1  <= cell_item.ray_start;
			near_s1   <= near(cell_item.root_x, cell_item.cell_x) &&
					near(cell_item.root_y, cell_item.cell_y) &&
					near(cell_item.root_z, cell_item.cell_z);
			ok_s1     <= in_grid && (cell_item.action == ACT_LIDAR ||
					cell_item.action == ACT_CAMERA || cell_item.action == ACT_ROBOT);
			addr_s1   <= raddr;
			ox_s1     <= cell_item.cell_x[5:0];
			oy_s1     <= cell_item.cell_y[5:0];
			oz_s1     <= cell_item.cell_z[5:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_valid_q <= 1'b0;
		end else if (done && res.emit) begin
			upd_valid_q <= 1'b1;
		end else if (!upd_stall) begin
			upd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res.emit) begin
			upd_item_q.out_x     <= ox_s1;
			upd_item_q.out_y     <= oy_s1;
			upd_item_q.out_z     <= oz_s1;
			upd_item_q.new_class <= res.wcell.cls;
		end
	end

	assign upd_valid = upd_valid_q;
	assign upd_item  = upd_item_q;

	// an item waiting on the output keeps reading the same cell
	a_hold_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !done) |=> (v_s1 && $stable(addr_s1)))
		else $error("held item lost its cell address");

	// cell writes outside the clearing pass come only from a finishing item
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(we && !clearing_q) |-> (done && ok_s1))
		else $error("cell write without a finishing item");

	// a result is only loaded when the class really changed
	a_emit_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.emit) |=> (upd_valid && upd_item.new_class != $past(cur.cls)))
		else $error("result loaded without a class change");

	// no item overtakes the clearing pass
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(clearing_q) && clearing_q |-> !v_s1)
		else $error("item in flight during clearing pass");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the voxel grid update block: streams of traced
// cells (lidar rays, camera rays, robot volumes and random noise) go in under
// several register settings and flow patterns; a grid model kept in the bench
// predicts every class change, and each one that comes out is checked field
// by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import vegu_pkg::*;

	// the run limit leaves a wide margin over the clearing pass after reset and
	// the far shorter rest of the run
	localparam int LIMIT_CYCLES  = 2_000_000;
	// margin after the drain covers the case where the last item, still inside
	// the block, causes no class change
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 185;
	localparam int PRINT_CAP     = 200;

	// the unused sensor kind
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_GAPS,
		FLOW_RECV_STALLS,
		FLOW_BOTH,
		FLOW_LONG_HOLD
	} flow_t;

	// ------------------------------------------------------------------------
	// block ports
	// ------------------------------------------------------------------------
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cell_valid = 1'b0;
	logic               cell_stall;
	in_item_t           cell_item  = '0;
	logic               upd_valid;
	logic               upd_stall  = 1'b0;
	out_item_t          upd_item;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr      = '0;
	logic [31:0]        pwdata     = '0;
	logic [31:0]        prdata;
	logic               pready;

	voxel_exploration_grid_update uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_item  (cell_item),
		.upd_valid  (upd_valid),
		.upd_stall  (upd_stall),
		.upd_item   (upd_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// grid model: occupancy, observed flag and class per cell, plus the
	// camera skipping flag and the register settings
	// ------------------------------------------------------------------------
	bit [OCC_BITS-1:0] occ_mem  [CELLS];
	bit                seen_mem [CELLS];
	class_t            cls_mem  [CELLS];
	bit                camera_skip;
	cfg_t              grid_cfg;

	out_item_t class_change_q [$];   // class changes still to come out
	in_item_t  cell_q [$];           // items waiting for the driver

	int  cells_queued    = 0;
	int  cells_taken     = 0;
	int  mismatches      = 0;
	int  cycles          = 0;
	int  hold_count      = 0;
	bit  cell_taken      = 1'b0;
	flow_t flow          = FLOW_FREE;

	// window of cells that the random rays stay around, per axis
	int win_lo [3];
	int win_w  [3];

	function automatic int axis_dim(input int a);
		return (a == 0) ? DIM_X : (a == 1) ? DIM_Y : DIM_Z;
	endfunction

	function automatic int axis_limit(input int a);
		int size;
		size = (a == 0) ? int'(grid_cfg.size_x) :
			(a == 1) ? int'(grid_cfg.size_y) : int'(grid_cfg.size_z);
		return (size < axis_dim(a)) ? size : axis_dim(a);
	endfunction

	function automatic bit on_grid(input logic signed [15:0] c, input int a);
		return (c >= 0) && (int'(c) < axis_limit(a));
	endfunction

	function automatic bit within_one(input logic signed [15:0] p, input logic signed [15:0] q);
		int d;
		d = int'(p) - int'(q);
		return (d >= -1) && (d <= 1);
	endfunction

	function automatic bit touches_grid(input in_item_t it);
		return (it.action != ACT_NONE) && on_grid(it.cell_x, 0) && on_grid(it.cell_y, 1) &&
			on_grid(it.cell_z, 2);
	endfunction

	// occupied wins over explored, explored over unoccupied
	function automatic class_t grade(input int idx);
		if (occ_mem[idx] > grid_cfg.occ_thr)
			return CLS_OCCUPIED;
		if (seen_mem[idx])
			return CLS_EXPLORED;
		if (occ_mem[idx] < grid_cfg.free_thr)
			return CLS_UNOCCUPIED;
		return CLS_UNKNOWN;
	endfunction

	// saturating step; the class is only refreshed when occupancy moves
	function automatic void step_occupancy(input int idx, input bit up, input int amount);
		int next;
		next = up ? int'(occ_mem[idx]) + amount : int'(occ_mem[idx]) - amount;
		if (next > int'(OCC_FULL))
			next = int'(OCC_FULL);
		if (next < 0)
			next = 0;
		if (next != int'(occ_mem[idx])) begin
			occ_mem[idx] = next[OCC_BITS-1:0];
			cls_mem[idx] = grade(idx);
		end
	endfunction

	// camera observation: blocked or unknown cells start skipping, which
	// only ends near the root or on a new ray
	function automatic void mark_seen(input int idx, input bit by_root);
		if (camera_skip && by_root)
			camera_skip = 1'b0;
		if (camera_skip)
			return;
		if (cls_mem[idx] == CLS_OCCUPIED || cls_mem[idx] == CLS_UNKNOWN) begin
			camera_skip = 1'b1;
			return;
		end
		if (!seen_mem[idx]) begin
			seen_mem[idx] = 1'b1;
			cls_mem[idx] = grade(idx);
		end
	endfunction

	function automatic void apply_cell(input in_item_t it);
		int        idx;
		class_t    was;
		bit        by_root;
		out_item_t chg;
		// ray start clears skipping even for ignored items
		if (it.ray_start)
			camera_skip = 1'b0;
		if (!touches_grid(it))
			return;
		idx = (int'(it.cell_x) * DIM_Y + int'(it.cell_y)) * DIM_Z + int'(it.cell_z);
		by_root = within_one(it.root_x, it.cell_x) && within_one(it.root_y, it.cell_y) &&
			within_one(it.root_z, it.cell_z);
		was = cls_mem[idx];
		case (it.action)
			ACT_LIDAR: begin
				step_occupancy(idx, it.hit,
					it.hit ? int'(grid_cfg.lidar_inc) : int'(grid_cfg.lidar_dec));
			end
			ACT_CAMERA: begin
				mark_seen(idx, by_root);
			end
			default: begin
				// robot volume: force full or empty, then observe
				step_occupancy(idx, it.hit, int'(OCC_FULL));
				mark_seen(idx, by_root);
			end
		endcase
		// only the class after the whole item counts
		if (cls_mem[idx] != was) begin
			chg.out_x     = it.cell_x[5:0];
			chg.out_y     = it.cell_y[5:0];
			chg.out_z     = it.cell_z[5:0];
			chg.new_class = cls_mem[idx];
			class_change_q = {class_change_q, chg};
		end
	endfunction

	task automatic note_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// monitor: check class changes, feed accepted items to the model
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		bit        took;
		took = 1'b0;
		if (arst_n) begin
			if (upd_valid === 1'b1 && upd_stall == 1'b0) begin
				if (class_change_q.size() == 0) begin
					note_mismatch($sformatf("class change (%0d,%0d,%0d) -> %0d with none due",
						upd_item.out_x, upd_item.out_y, upd_item.out_z, upd_item.new_class));
				end else begin
					want = class_change_q.pop_front();
					if (upd_item.out_x !== want.out_x)
						note_mismatch($sformatf("out_x got %0d want %0d", upd_item.out_x,
							want.out_x));
					if (upd_item.out_y !== want.out_y)
						note_mismatch($sformatf("out_y got %0d want %0d", upd_item.out_y,
							want.out_y));
					if (upd_item.out_z !== want.out_z)
						note_mismatch($sformatf("out_z got %0d want %0d", upd_item.out_z,
							want.out_z));
					if (upd_item.new_class !== want.new_class)
						note_mismatch($sformatf("new_class got %0d want %0d at (%0d,%0d,%0d)",
							upd_item.new_class, want.new_class, want.out_x, want.out_y,
							want.out_z));
				end
			end
			if (cell_valid && cell_stall === 1'b0) begin
				apply_cell(cell_item);
				cells_taken++;
				took = 1'b1;
			end
		end
		cell_taken <= took;
	end

	// ------------------------------------------------------------------------
	// driver: new item only once the current one has gone in
	// ------------------------------------------------------------------------
	function automatic bit sender_rests();
		case (flow)
			FLOW_SEND_GAPS: return $urandom_range(0, 99) < 78;
			FLOW_BOTH:      return $urandom_range(0, 99) < 38;
			default:        return 1'b0;
		endcase
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			cell_valid <= 1'b0;
		end else if (!cell_valid || cell_taken) begin
			if (cell_q.size() != 0 && !sender_rests()) begin
				cell_item  <= cell_q.pop_front();
				cell_valid <= 1'b1;
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, or one long hold-off at the start of the
	// hold phase so that the block backs up into the cell channel
	always @(negedge clk) begin
		if (flow == FLOW_LONG_HOLD)
			hold_count <= hold_count + 1;
		else
			hold_count <= 0;
		case (flow)
			FLOW_RECV_STALLS: upd_stall <= $urandom_range(0, 99) < 78;
			FLOW_BOTH:        upd_stall <= $urandom_range(0, 99) < 38;
			FLOW_LONG_HOLD:   upd_stall <= hold_count < HOLD_CYCLES;
			default:          upd_stall <= 1'b0;
		endcase
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[voxel_exploration_grid_update] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] which, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_LIDAR_INC, 32'(c.lidar_inc));
		write_reg(REG_LIDAR_DEC, 32'(c.lidar_dec));
		write_reg(REG_OCC_THR, 32'(c.occ_thr));
		write_reg(REG_FREE_THR, 32'(c.free_thr));
		write_reg(REG_SIZE_X, 32'(c.size_x));
		write_reg(REG_SIZE_Y, 32'(c.size_y));
		write_reg(REG_SIZE_Z, 32'(c.size_z));
		grid_cfg = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.lidar_inc = 8'($urandom_range(1, 128));
		c.lidar_dec = 8'($urandom_range(1, 128));
		c.occ_thr   = 8'($urandom_range(129, 250));
		c.free_thr  = 8'($urandom_range(10, 127));
		c.size_x    = 7'($urandom_range(6, 64));
		c.size_y    = 7'($urandom_range(6, 64));
		c.size_z    = 7'($urandom_range(6, 64));
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic queue_cell(input logic [1:0] act, input int x, input int y, input int z,
			input bit hit, input bit start, input int rx, input int ry, input int rz);
		in_item_t it;
		it.action    = act;
		it.cell_x    = 16'(x);
		it.cell_y    = 16'(y);
		it.cell_z    = 16'(z);
		it.hit       = hit;
		it.ray_start = start;
		it.root_x    = 16'(rx);
		it.root_y    = 16'(ry);
		it.root_z    = 16'(rz);
		cell_q = {cell_q, it};
		cells_queued++;
	endtask

	// mostly inside the window, now and then one cell beyond either side
	function automatic int pick_coord(input int a);
		return win_lo[a] - 1 + int'($urandom_range(0, win_w[a] + 1));
	endfunction

	task automatic place_window();
		int lim;
		foreach (win_lo[a]) begin
			lim = axis_limit(a);
			win_w[a] = (lim < 6) ? lim : 6;
			win_lo[a] = (lim > win_w[a]) ? int'($urandom_range(0, lim - win_w[a])) : 0;
		end
	endtask

	// straight ray from the root cell; lidar passes through and may end in
	// a hit, camera rays sometimes have their root placed off to one side
	task automatic queue_ray(input logic [1:0] act);
		int r [3];
		int d [3];
		int len;
		int rx;
		bit start_ok;
		bit ends_hit;
		foreach (r[a]) begin
			r[a] = pick_coord(a);
			d[a] = int'($urandom_range(0, 2)) - 1;
		end
		len      = $urandom_range(2, 7);
		start_ok = $urandom_range(0, 9) != 0;
		ends_hit = $urandom_range(0, 3) != 0;
		rx       = (act == ACT_CAMERA && $urandom_range(0, 4) == 0) ? r[0] + 3 : r[0];
		for (int k = 0; k < len; k++)
			queue_cell(act, r[0] + k * d[0], r[1] + k * d[1], r[2] + k * d[2],
				(act == ACT_LIDAR) ? (ends_hit && k == len - 1) : bit'($urandom_range(0, 1)),
				start_ok && k == 0, rx, r[1], r[2]);
	endtask

	// robot body: cells around the root, mostly all hit or all clear
	task automatic queue_volume();
		int r [3];
		int n;
		bit hit;
		foreach (r[a])
			r[a] = pick_coord(a);
		n   = $urandom_range(3, 9);
		hit = bit'($urandom_range(0, 1));
		for (int k = 0; k < n; k++)
			queue_cell(ACT_ROBOT, r[0] + int'($urandom_range(0, 2)) - 1,
				r[1] + int'($urandom_range(0, 2)) - 1, r[2] + int'($urandom_range(0, 2)) - 1,
				($urandom_range(0, 7) == 0) ? !hit : hit, k == 0, r[0], r[1], r[2]);
	endtask

	task automatic queue_noise();
		queue_cell(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
			bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), $urandom, $urandom,
			$urandom);
	endtask

	task automatic queue_random(input int budget);
		int all0;
		int pick;
		all0 = cells_queued;
		while (cells_queued - all0 < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				queue_ray(ACT_LIDAR);
			else if (pick < 72)
				queue_ray(ACT_CAMERA);
			else if (pick < 88)
				queue_volume();
			else
				queue_noise();
		end
	endtask

	// everything queued has gone in and every class change has come out
	task automatic wait_drained(input int extra);
		do @(negedge clk); while (cells_taken != cells_queued || class_change_q.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic run_phase(input cfg_t c, input flow_t f, input int budget);
		wait_drained(SETTLE_CYCLES);
		load_config(c);
		flow = f;
		place_window();
		queue_random(budget);
	endtask

	task automatic queue_directed();
		// lidar hit from one half straight to occupied
		queue_cell(ACT_LIDAR, 1, 1, 1, 1'b1, 1'b0, 1, 1, 1);
		// two misses: unknown, then unoccupied
		queue_cell(ACT_LIDAR, 2, 2, 2, 1'b0, 1'b0, 2, 2, 2);
		queue_cell(ACT_LIDAR, 2, 2, 2, 1'b0, 1'b0, 2, 2, 2);
		queue_cell(ACT_LIDAR, 6, 2, 2, 1'b0, 1'b0, 6, 2, 2);
		queue_cell(ACT_LIDAR, 6, 2, 2, 1'b0, 1'b0, 6, 2, 2);
		// camera on a free cell: explored
		queue_cell(ACT_CAMERA, 2, 2, 2, 1'b0, 1'b1, 2, 2, 2);
		// occupied cell starts skipping
		queue_cell(ACT_CAMERA, 1, 1, 1, 1'b0, 1'b0, 2, 2, 2);
		// far from the root: skipped even though it is free
		queue_cell(ACT_CAMERA, 6, 2, 2, 1'b0, 1'b0, 2, 2, 2);
		// back near the root: skipping ends, unknown cell starts it again
		queue_cell(ACT_CAMERA, 3, 3, 3, 1'b1, 1'b0, 2, 2, 2);
		// unused action with ray start: clears skipping, nothing else
		queue_cell(ACT_NONE, 4, 4, 4, 1'b1, 1'b1, 4, 4, 4);
		queue_cell(ACT_CAMERA, 6, 2, 2, 1'b0, 1'b0, 6, 2, 2);
		// robot miss: unoccupied then explored in one item
		queue_cell(ACT_ROBOT, 6, 6, 6, 1'b0, 1'b1, 6, 6, 6);
		queue_cell(ACT_ROBOT, 7, 7, 7, 1'b1, 1'b0, 6, 6, 6);
		// saturation at both ends
		queue_cell(ACT_LIDAR, 6, 6, 6, 1'b0, 1'b0, 6, 6, 6);
		queue_cell(ACT_LIDAR, 7, 7, 7, 1'b1, 1'b0, 7, 7, 7);
		// outside the grid: negative, far and just past the edge
		queue_cell(ACT_LIDAR, -1, 0, 0, 1'b1, 1'b0, 0, 0, 0);
		queue_cell(ACT_LIDAR, 32767, -32768, 0, 1'b1, 1'b0, 32767, -32768, 0);
		queue_cell(ACT_ROBOT, 63, 63, 64, 1'b1, 1'b0, 63, 63, 63);
		// top corner cell
		queue_cell(ACT_LIDAR, 63, 63, 63, 1'b0, 1'b0, 63, 63, 63);
		queue_cell(ACT_LIDAR, 63, 63, 63, 1'b0, 1'b0, 63, 63, 63);
		queue_cell(ACT_CAMERA, 63, 63, 63, 1'b0, 1'b1, -32768, 32767, -1);
		queue_cell(ACT_ROBOT, 0, 0, 0, 1'b1, 1'b1, 32767, -32768, 2);
		// root two cells away: not near
		queue_cell(ACT_CAMERA, 5, 5, 5, 1'b0, 1'b0, 7, 5, 5);
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			occ_mem[i]  = OCC_HALF;
			seen_mem[i] = 1'b0;
			cls_mem[i]  = CLS_UNKNOWN;
		end
		camera_skip = 1'b0;
		grid_cfg = cfg_t'{8'd64, 8'd32, 8'd178, 8'd76, 7'd64, 7'd64, 7'd64};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers go in during the clearing pass; items wait on the stall
		load_config(cfg_t'{8'd64, 8'd32, 8'd178, 8'd76, 7'd64, 7'd64, 7'd64});
		flow = FLOW_FREE;
		queue_directed();

		run_phase(cfg_t'{8'd255, 8'd255, 8'd0, 8'd255, 7'd1, 7'd64, 7'd127},
			FLOW_SEND_GAPS, PHASE_ITEMS);
		run_phase(cfg_t'{8'd0, 8'd0, 8'd255, 8'd0, 7'd64, 7'd2, 7'd64},
			FLOW_RECV_STALLS, PHASE_ITEMS);
		run_phase(random_cfg(), FLOW_BOTH, PHASE_ITEMS);
		run_phase(random_cfg(), FLOW_LONG_HOLD, PHASE_ITEMS);
		// zero size on x: every cell ignored, so only a short burst
		run_phase(cfg_t'{8'd17, 8'd200, 8'd128, 8'd128, 7'd0, 7'd64, 7'd64}, FLOW_FREE, 10);
		run_phase(random_cfg(), FLOW_BOTH, PHASE_ITEMS);
		run_phase(cfg_t'{8'd255, 8'd1, 8'd128, 8'd127, 7'd64, 7'd64, 7'd64},
			FLOW_SEND_GAPS, PHASE_ITEMS);
		run_phase(random_cfg(), FLOW_RECV_STALLS, PHASE_ITEMS);
		run_phase(random_cfg(), FLOW_FREE, PHASE_ITEMS);

		wait_drained(4 * SETTLE_CYCLES);
		if (mismatches == 0) begin
			$display("[voxel_exploration_grid_update] OK");
		end else begin
			$display("[voxel_exploration_grid_update] ERROR");
		end
		$finish;
	end

endmodule
